### rtl/itpl_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// itpl_pkg
// Shared types and codes for the interval table position locator.
// ----------------------------------------------------------------------------
package itpl_pkg;

  localparam int FIELD_POS_W = 48;
  localparam int FIELD_IDX_W = 6;
  localparam int CFG_W       = 7;

  // Item mode codes as they arrive on the input transfer.
  localparam logic [1:0] MODE_LOAD   = 2'd0;
  localparam logic [1:0] MODE_LOCATE = 2'd1;
  localparam logic [1:0] MODE_NEXT   = 2'd2;

  typedef struct packed {
    logic [1:0]             mode;
    logic [FIELD_IDX_W-1:0] entry_index;
    logic [FIELD_POS_W-1:0] entry_begin;
    logic [FIELD_POS_W-1:0] entry_length;
    logic [FIELD_POS_W-1:0] lookup_pos;
  } in_item_t;

  typedef struct packed {
    logic                   found;
    logic [FIELD_IDX_W-1:0] hit_index;
    logic [FIELD_POS_W-1:0] result_position;
  } out_item_t;

  // Operation decided by the front end.
  typedef enum logic [1:0] {
    OP_NONE,
    OP_LOAD,
    OP_LOCATE,
    OP_NEXT
  } cmd_op_t;

  typedef struct packed {
    cmd_op_t                op;
    logic [FIELD_IDX_W-1:0] slot;
    logic [FIELD_POS_W-1:0] begin_pos;
    logic [FIELD_POS_W-1:0] length;
    logic [FIELD_POS_W-1:0] query_pos;
  } cmd_t;

  typedef enum logic [1:0] {
    BK_IDLE,
    BK_EXEC,
    BK_SCAN,
    BK_FINISH
  } back_state_t;

endpackage

### rtl/itpl_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// itpl_front
// Accepts items, decodes them into commands and queues them for the back end.
// ----------------------------------------------------------------------------
module itpl_front #(
  parameter int MAX_ENTRIES   = 64,
  parameter int POSITION_BITS = 48
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             start,
  output logic             busy,
  input  itpl_pkg::in_item_t item,
  output logic             cmd_valid,
  input  logic             cmd_ready,
  output itpl_pkg::cmd_t   cmd
);
  import itpl_pkg::*;

  localparam int PW = (POSITION_BITS < FIELD_POS_W) ? POSITION_BITS : FIELD_POS_W;
  localparam logic [FIELD_POS_W-1:0] POS_MASK = {FIELD_POS_W{1'b1}} >> (FIELD_POS_W - PW);

  cmd_t       queue [2];
  logic       wr_ptr;
  logic       rd_ptr;
  logic [1:0] count;
  cmd_t       decoded;
  logic       push;
  logic       pop;

  // Decode the incoming item; a load to a slot past the table acts as a no-op.
  always_comb begin
    decoded.slot      = item.entry_index;
    decoded.begin_pos = item.entry_begin & POS_MASK;
    decoded.length    = item.entry_length & POS_MASK;
    decoded.query_pos = item.lookup_pos & POS_MASK;
    unique case (item.mode)
      MODE_LOAD:   decoded.op = (32'(item.entry_index) < 32'(MAX_ENTRIES)) ? OP_LOAD : OP_NONE;
      MODE_LOCATE: decoded.op = OP_LOCATE;
      MODE_NEXT:   decoded.op = OP_NEXT;
      default:     decoded.op = OP_NONE;
    endcase
  end

  assign busy      = (count == 2'd2);
  assign push      = start && !busy;
  assign cmd_valid = (count != 2'd0);
  assign pop       = cmd_valid && cmd_ready;
  assign cmd       = queue[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (push) wr_ptr <= !wr_ptr;
      if (pop) rd_ptr <= !rd_ptr;
      count <= count + {1'b0, push} - {1'b0, pop};
    end
  end

  always_ff @(posedge clk) begin
    if (push) queue[wr_ptr] <= decoded;
  end

endmodule

### rtl/itpl_back.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// itpl_back
// Holds the interval table and carries out loads and table scans.
// ----------------------------------------------------------------------------
module itpl_back #(
  parameter int MAX_ENTRIES   = 64,
  parameter int POSITION_BITS = 48
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic [itpl_pkg::CFG_W-1:0]   entries_in_use,
  input  logic                         cmd_valid,
  output logic                         cmd_ready,
  input  itpl_pkg::cmd_t               cmd,
  output logic                         done,
  output itpl_pkg::out_item_t          result
);
  import itpl_pkg::*;

  localparam int PW    = (POSITION_BITS < FIELD_POS_W) ? POSITION_BITS : FIELD_POS_W;
  localparam int IDX_W = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
  localparam int CNT_W = $clog2(MAX_ENTRIES + 1);
  localparam int CW    = (CNT_W > CFG_W) ? CNT_W : CFG_W;

  back_state_t state;
  back_state_t state_next;
  cmd_t        cur;

  logic [PW-1:0]    begin_mem  [MAX_ENTRIES];
  logic [PW-1:0]    length_mem [MAX_ENTRIES];
  logic [MAX_ENTRIES-1:0] entry_valid;

  logic [CNT_W-1:0] count_lim;
  logic [CNT_W-1:0] count_lim_next;
  logic [CNT_W-1:0] issue_cnt;
  logic             pipe_live;
  logic             pipe_ok;
  logic [IDX_W-1:0] pipe_idx;
  logic [PW-1:0]    rd_begin;
  logic [PW-1:0]    rd_len;

  logic             have;
  logic             exact;
  logic [IDX_W-1:0] best_idx;
  logic [PW-1:0]    best_begin;
  logic [PW-1:0]    best_len;

  logic             is_search;
  logic             issue;
  logic             do_write;
  logic             take;
  logic             take_exact;
  logic [PW-1:0]    pos;
  logic [PW-1:0]    offset;
  logic [IDX_W-1:0] raddr;
  logic [IDX_W-1:0] waddr;
  logic             done_next;
  out_item_t        result_next;

  assign pos       = cur.query_pos[PW-1:0];
  assign is_search = (cur.op == OP_LOCATE) || (cur.op == OP_NEXT);
  assign raddr     = issue_cnt[IDX_W-1:0];
  assign waddr     = IDX_W'(cur.slot);
  assign offset    = pos - best_begin;

  // Active entry count, clamped to the table size.
  always_comb begin
    if (CW'(entries_in_use) > CW'(MAX_ENTRIES)) count_lim_next = CNT_W'(MAX_ENTRIES);
    else count_lim_next = CNT_W'(entries_in_use);
  end

  always_comb begin
    state_next = state;
    unique case (state)
      BK_IDLE:   if (cmd_valid) state_next = BK_EXEC;
      BK_EXEC:   state_next = is_search ? BK_SCAN : BK_IDLE;
      BK_SCAN:   if (issue_cnt == count_lim && !pipe_live) state_next = BK_FINISH;
      BK_FINISH: state_next = BK_IDLE;
      default:   state_next = BK_IDLE;
    endcase
  end

  always_comb begin
    cmd_ready = (state == BK_IDLE);
    do_write  = (state == BK_EXEC) && (cur.op == OP_LOAD);
    issue     = (state == BK_SCAN) && (issue_cnt < count_lim);
  end

  // Candidate test for the entry coming out of the table read.
  always_comb begin
    take       = 1'b0;
    take_exact = 1'b0;
    if (state == BK_SCAN && pipe_live && pipe_ok) begin
      if (cur.op == OP_LOCATE) begin
        if (rd_begin == pos) begin
          take       = !exact;
          take_exact = !exact;
        end else if (rd_begin < pos) begin
          take = !exact && (!have || rd_begin >= best_begin);
        end
      end else begin
        take = (rd_begin > pos) && (!have || rd_begin < best_begin);
      end
    end
  end

  always_comb begin
    done_next   = 1'b0;
    result_next = '0;
    if (state == BK_EXEC && !is_search) begin
      done_next = 1'b1;
      if (cur.op == OP_LOAD) begin
        result_next.found     = 1'b1;
        result_next.hit_index = cur.slot;
      end
    end else if (state == BK_FINISH) begin
      done_next = 1'b1;
      if (cur.op == OP_LOCATE) begin
        if (have && offset < best_len) begin
          result_next.found           = 1'b1;
          result_next.hit_index       = FIELD_IDX_W'(best_idx);
          result_next.result_position = FIELD_POS_W'(offset);
        end
      end else if (have) begin
        result_next.found           = 1'b1;
        result_next.hit_index       = FIELD_IDX_W'(best_idx);
        result_next.result_position = FIELD_POS_W'(best_begin);
      end else begin
        result_next.result_position = '1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= BK_IDLE;
      pipe_live   <= 1'b0;
      done        <= 1'b0;
      entry_valid <= '0;
    end else begin
      state     <= state_next;
      pipe_live <= issue;
      done      <= done_next;
      if (do_write) entry_valid[waddr] <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (state == BK_IDLE && cmd_valid) cur <= cmd;
    result <= result_next;
    if (issue) begin
      pipe_ok  <= entry_valid[raddr];
      pipe_idx <= raddr;
    end
    if (state == BK_EXEC) begin
      count_lim <= count_lim_next;
      issue_cnt <= '0;
      have      <= 1'b0;
      exact     <= 1'b0;
    end else begin
      if (issue) issue_cnt <= CNT_W'(issue_cnt + 1'b1);
      if (take) begin
        have       <= 1'b1;
        best_idx   <= pipe_idx;
        best_begin <= rd_begin;
        best_len   <= rd_len;
      end
      if (take_exact) exact <= 1'b1;
    end
  end

  // Table memories: one write port, one registered read port.
  always_ff @(posedge clk) begin
    if (do_write) begin
      begin_mem[waddr]  <= cur.begin_pos[PW-1:0];
      length_mem[waddr] <= cur.length[PW-1:0];
    end
    if (issue) begin
      rd_begin <= begin_mem[raddr];
      rd_len   <= length_mem[raddr];
    end
  end

endmodule

### rtl/interval_table_position_locator.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// interval_table_position_locator
// Table of intervals with load, locate-position and find-next operations.
// ----------------------------------------------------------------------------
// Usage: drive an item on the item port and raise start; the transfer happens
// at a rising edge where start is high and busy is low. Mode 0 loads a table
// slot, mode 1 locates the interval holding lookup_pos (index and offset),
// mode 2 finds the next interval starting above lookup_pos.
// Each item produces exactly one result, shown on the result port for one
// cycle while done is high. The receiver cannot stall, so results never wait.
// Items enter a two-deep command queue; busy rises only when it is full.
// A load or reserved item is answered from the back end's execute state. A
// search scans the first n entries through a single-port table read, one entry
// per cycle, where n is entries_in_use clamped to MAX_ENTRIES; the back end
// takes no new command from the queue until the scan has finished.
// Results come back in the order items were taken.
// Configuration: cfg_we writes entries_in_use from cfg_wdata; write it only
// while no item is in flight. Reset clears the register, the queue and every
// entry's valid bit, so a table slot only takes part once it has been loaded.
// ----------------------------------------------------------------------------
module interval_table_position_locator #(
  parameter int MAX_ENTRIES   = 64,
  parameter int POSITION_BITS = 48
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       start,
  output logic                       busy,
  input  itpl_pkg::in_item_t         item,
  output logic                       done,
  output itpl_pkg::out_item_t        result,
  input  logic                       cfg_we,
  input  logic [itpl_pkg::CFG_W-1:0] cfg_wdata
);
  import itpl_pkg::*;

  // Number of table entries that take part in searches.
  logic [CFG_W-1:0] entries_in_use;

  logic cmd_valid;
  logic cmd_ready;
  cmd_t cmd;

  always_ff @(posedge clk) begin
    if (rst) begin
      entries_in_use <= '0;
    end else if (cfg_we) begin
      entries_in_use <= cfg_wdata;
    end
  end

  // Front end: takes the transfer, decodes the mode and queues the command.
  itpl_front #(
    .MAX_ENTRIES  (MAX_ENTRIES),
    .POSITION_BITS(POSITION_BITS)
  ) u_front (
    .clk      (clk),
    .rst      (rst),
    .start    (start),
    .busy     (busy),
    .item     (item),
    .cmd_valid(cmd_valid),
    .cmd_ready(cmd_ready),
    .cmd      (cmd)
  );

  // Back end: owns the table, performs loads and scans, registers the result.
  itpl_back #(
    .MAX_ENTRIES  (MAX_ENTRIES),
    .POSITION_BITS(POSITION_BITS)
  ) u_back (
    .clk           (clk),
    .rst           (rst),
    .entries_in_use(entries_in_use),
    .cmd_valid     (cmd_valid),
    .cmd_ready     (cmd_ready),
    .cmd           (cmd),
    .done          (done),
    .result        (result)
  );

endmodule

### tb/itpl_result_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// itpl_result_checker
// Watches the item, result and register channels of the interval table
// position locator, predicts each answer and compares it field by field.
// ----------------------------------------------------------------------------
module itpl_result_checker (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       start,
  input  logic                       busy,
  input  itpl_pkg::in_item_t         item,
  input  logic                       done,
  input  itpl_pkg::out_item_t        result,
  input  logic                       cfg_we,
  input  logic [itpl_pkg::CFG_W-1:0] cfg_wdata,
  output int                         fail_count,
  output int                         outstanding
);
  import itpl_pkg::*;

  localparam int TABLE_DEPTH = 64;
  localparam int REPORT_LIMIT = 10;

  // Private copy of the interval table and the register.
  logic [FIELD_POS_W-1:0] span_begin [TABLE_DEPTH];
  logic [FIELD_POS_W-1:0] span_len   [TABLE_DEPTH];
  logic                   span_valid [TABLE_DEPTH];
  logic [CFG_W-1:0]       active_limit;

  out_item_t answers_due [$];

  // Computes the answer for one item and applies a load to the private table.
  function automatic out_item_t table_answer(input in_item_t it);
    out_item_t              ans;
    int                     n;
    int                     best;
    logic                   have;
    logic                   exact;
    logic [FIELD_POS_W-1:0] best_b;
    logic [FIELD_POS_W-1:0] b;
    logic [FIELD_POS_W-1:0] pos;
    ans    = '0;
    have   = 1'b0;
    exact  = 1'b0;
    best   = 0;
    best_b = '0;
    pos    = it.lookup_pos;
    n      = (int'(active_limit) > TABLE_DEPTH) ? TABLE_DEPTH : int'(active_limit);
    case (it.mode)
      MODE_LOAD: begin
        span_begin[it.entry_index] = it.entry_begin;
        span_len[it.entry_index]   = it.entry_length;
        span_valid[it.entry_index] = 1'b1;
        ans.found     = 1'b1;
        ans.hit_index = it.entry_index;
      end
      MODE_LOCATE: begin
        for (int i = 0; i < n; i++) begin
          b = span_begin[i];
          if (span_valid[i] && b <= pos) begin
            if (b == pos) begin
              // An exact begin wins outright; the lowest such index is kept.
              if (!exact) begin
                exact  = 1'b1;
                have   = 1'b1;
                best   = i;
                best_b = b;
              end
            end else if (!exact && (!have || b >= best_b)) begin
              have   = 1'b1;
              best   = i;
              best_b = b;
            end
          end
        end
        if (have && (pos - best_b) < span_len[best]) begin
          ans.found           = 1'b1;
          ans.hit_index       = best[FIELD_IDX_W-1:0];
          ans.result_position = pos - best_b;
        end
      end
      MODE_NEXT: begin
        for (int i = 0; i < n; i++) begin
          b = span_begin[i];
          if (span_valid[i] && b > pos && (!have || b < best_b)) begin
            have   = 1'b1;
            best   = i;
            best_b = b;
          end
        end
        if (have) begin
          ans.found           = 1'b1;
          ans.hit_index       = best[FIELD_IDX_W-1:0];
          ans.result_position = best_b;
        end else begin
          ans.result_position = '1;
        end
      end
      default: ans = '0;
    endcase
    return ans;
  endfunction

  always @(posedge clk) begin
    out_item_t want;
    if (rst) begin
      for (int i = 0; i < TABLE_DEPTH; i++) begin
        span_begin[i] = '0;
        span_len[i]   = '0;
        span_valid[i] = 1'b0;
      end
      active_limit = '0;
      answers_due.delete();
      fail_count  = 0;
      outstanding = 0;
    end else begin
      if (cfg_we === 1'b1) begin
        active_limit = cfg_wdata;
      end
      // A result is compared before a new item of the same edge is queued.
      if (done === 1'b1) begin
        if (answers_due.size() == 0) begin
          if (fail_count < REPORT_LIMIT) begin
            $display("[%0t] unexpected result: found=%b index=%0d position=%h",
                     $realtime, result.found, result.hit_index, result.result_position);
          end
          fail_count++;
        end else begin
          want = answers_due.pop_front();
          if (result.found !== want.found || result.hit_index !== want.hit_index ||
              result.result_position !== want.result_position) begin
            if (fail_count < REPORT_LIMIT) begin
              $display("[%0t] result mismatch: expected found=%b index=%0d position=%h",
                       $realtime, want.found, want.hit_index, want.result_position);
              $display("[%0t]                  actual   found=%b index=%0d position=%h",
                       $realtime, result.found, result.hit_index, result.result_position);
            end
            fail_count++;
          end
        end
      end
      if (start === 1'b1 && busy === 1'b0) begin
        answers_due = {answers_due, table_answer(item)};
      end
      outstanding = answers_due.size();
    end
  end

endmodule

### tb/tb_interval_table_position_locator.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_interval_table_position_locator
// Drives directed and random load, locate and next items into the interval
// table position locator across several entries_in_use settings, with random
// gaps between transfers. A separate checker predicts and compares every
// result; this module makes stimulus and gives the verdict.
// ----------------------------------------------------------------------------
module tb_interval_table_position_locator;
  import itpl_pkg::*;

  // The package names only the three real modes; the fourth code is unused.
  localparam logic [1:0] MODE_RESERVED = 2'd3;

  localparam int TABLE_SLOTS     = 64;
  localparam int RANDOM_PHASES   = 8;
  localparam int ITEMS_PER_PHASE = 190;
  localparam int MAX_GAP         = 13;
  // The watchdog allows many times the length of a full search.
  localparam int IDLE_LIMIT      = 4000;
  localparam int DRAIN_CYCLES    = 100;
  localparam logic [FIELD_POS_W-1:0] POS_ALL_ONES = '1;

  logic                   clk = 1'b0;
  logic                   rst = 1'b1;
  logic                   start = 1'b0;
  logic                   busy;
  in_item_t               item = '0;
  logic                   done;
  out_item_t              result;
  logic                   cfg_we = 1'b0;
  logic [CFG_W-1:0]       cfg_wdata = '0;

  int fail_count;
  int outstanding;
  int idle_cycles;
  int calm_left;

  // Begins this module has loaded, used only to aim queries near intervals.
  logic [FIELD_POS_W-1:0] shadow_begin [TABLE_SLOTS];

  always #10 clk = ~clk;

  interval_table_position_locator dut (
    .clk       (clk),
    .rst       (rst),
    .start     (start),
    .busy      (busy),
    .item      (item),
    .done      (done),
    .result    (result),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata)
  );

  itpl_result_checker u_checker (
    .clk         (clk),
    .rst         (rst),
    .start       (start),
    .busy        (busy),
    .item        (item),
    .done        (done),
    .result      (result),
    .cfg_we      (cfg_we),
    .cfg_wdata   (cfg_wdata),
    .fail_count  (fail_count),
    .outstanding (outstanding)
  );

  // The watchdog restarts whenever an item or a result makes a transfer.
  always @(posedge clk) begin
    if (rst) begin
      idle_cycles <= 0;
    end else if ((start === 1'b1 && busy === 1'b0) || done === 1'b1) begin
      idle_cycles <= 0;
    end else if (idle_cycles + 1 >= IDLE_LIMIT) begin
      $display("CHECK FAILED");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  function automatic logic [FIELD_POS_W-1:0] any_position();
    logic [63:0] w;
    w = {$urandom, $urandom};
    return w[FIELD_POS_W-1:0];
  endfunction

  // Every field is random first, so unused fields still toggle every bit.
  function automatic in_item_t noise_item();
    in_item_t it;
    it.mode           = 2'($urandom_range(0, 3));
    it.entry_index    = FIELD_IDX_W'($urandom_range(0, TABLE_SLOTS - 1));
    it.entry_begin    = any_position();
    it.entry_length   = any_position();
    it.lookup_pos     = any_position();
    return it;
  endfunction

  function automatic in_item_t load_item(input int slot, input logic [FIELD_POS_W-1:0] b,
                                         input logic [FIELD_POS_W-1:0] len);
    in_item_t it;
    it             = noise_item();
    it.mode        = MODE_LOAD;
    it.entry_index = slot[FIELD_IDX_W-1:0];
    it.entry_begin = b;
    it.entry_length = len;
    return it;
  endfunction

  function automatic in_item_t query_item(input logic [1:0] mode,
                                          input logic [FIELD_POS_W-1:0] pos);
    in_item_t it;
    it                = noise_item();
    it.mode           = mode;
    it.lookup_pos     = pos;
    return it;
  endfunction

  // Most random items build a compact table and then search close to its
  // begins and ends; a tenth are pure noise, reserved modes included.
  function automatic in_item_t random_item(input int load_weight);
    in_item_t               it;
    int                     pick;
    int                     slot;
    logic [FIELD_POS_W-1:0] b;
    logic [FIELD_POS_W-1:0] len;
    logic [FIELD_POS_W-1:0] pos;
    pick = $urandom_range(0, 99);
    slot = $urandom_range(0, TABLE_SLOTS - 1);
    if (pick < 10) begin
      it = noise_item();
    end else if (pick < 10 + load_weight) begin
      if ($urandom_range(0, 15) == 0) begin
        // Intervals at the very top of the position range.
        b   = POS_ALL_ONES - FIELD_POS_W'($urandom_range(0, 500));
        len = FIELD_POS_W'($urandom_range(0, 600));
      end else begin
        b   = FIELD_POS_W'($urandom_range(0, 4095));
        len = ($urandom_range(0, 3) == 0) ? FIELD_POS_W'($urandom_range(0, 2)) :
                                            FIELD_POS_W'($urandom_range(1, 300));
      end
      it = load_item(slot, b, len);
    end else begin
      case ($urandom_range(0, 5))
        0: pos = shadow_begin[slot];
        1: pos = shadow_begin[slot] - 1;
        2: pos = shadow_begin[slot] + 1;
        3: pos = shadow_begin[slot] + FIELD_POS_W'($urandom_range(0, 320));
        4: pos = FIELD_POS_W'($urandom_range(0, 4500));
        default: pos = ($urandom_range(0, 1) == 1) ? POS_ALL_ONES : '0;
      endcase
      it = query_item(($urandom_range(0, 1) == 1) ? MODE_LOCATE : MODE_NEXT, pos);
    end
    return it;
  endfunction

  // Presents one item after a random gap and returns at the falling edge
  // after its transfer, with start still high so back-to-back items flow.
  task automatic send_item(input in_item_t it);
    int   gap;
    logic taken;
    if (calm_left > 0) begin
      gap = 0;
      calm_left--;
    end else if ($urandom_range(0, 19) == 0) begin
      gap = 0;
      calm_left = $urandom_range(20, 60);
    end else begin
      gap = $urandom_range(0, MAX_GAP);
    end
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    item  <= it;
    start <= 1'b1;
    if (it.mode == MODE_LOAD) begin
      shadow_begin[it.entry_index] = it.entry_begin;
    end
    taken = 1'b0;
    while (!taken) begin
      @(posedge clk);
      taken = (busy === 1'b0);
      @(negedge clk);
    end
  endtask

  // The register is only written once every result has come back.
  task automatic write_entries_in_use(input logic [CFG_W-1:0] value);
    start <= 1'b0;
    while (outstanding != 0) @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_wdata <= value;
    @(negedge clk);
    cfg_we    <= 1'b0;
  endtask

  logic [CFG_W-1:0] phase_limit [RANDOM_PHASES];

  initial begin
    calm_left = 0;
    for (int i = 0; i < TABLE_SLOTS; i++) shadow_begin[i] = '0;
    phase_limit[0] = 7'd64;
    phase_limit[1] = 7'd1;
    phase_limit[2] = 7'd63;
    phase_limit[3] = 7'd0;
    phase_limit[4] = 7'd65;
    phase_limit[5] = CFG_W'($urandom_range(2, 62));
    phase_limit[6] = 7'd127;
    phase_limit[7] = CFG_W'($urandom_range(0, 127));

    repeat (11) @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // With no entries in use every search misses, and loads still land.
    write_entries_in_use(7'd0);
    send_item(query_item(MODE_LOCATE, '0));
    send_item(query_item(MODE_NEXT, '0));
    send_item(query_item(MODE_RESERVED, any_position()));
    send_item(load_item(0, 48'd0, 48'd10));
    send_item(load_item(1, 48'd100, 48'd50));
    send_item(load_item(2, 48'd100, 48'd5));
    send_item(load_item(63, POS_ALL_ONES, POS_ALL_ONES));
    send_item(load_item(5, 48'd1000, 48'd0));
    send_item(query_item(MODE_LOCATE, 48'd5));

    // An oversized count acts as the full table.
    write_entries_in_use(7'd127);
    send_item(query_item(MODE_LOCATE, 48'd0));
    send_item(query_item(MODE_LOCATE, 48'd9));
    // One past the end of an interval is a miss.
    send_item(query_item(MODE_LOCATE, 48'd10));
    send_item(query_item(MODE_LOCATE, 48'd50));
    // Equal begins: an exact match takes the lowest index, a position above
    // them takes the highest index, which here is too short to hold it.
    send_item(query_item(MODE_LOCATE, 48'd100));
    send_item(query_item(MODE_LOCATE, 48'd120));
    send_item(query_item(MODE_LOCATE, 48'd102));
    // A zero-length interval holds nothing.
    send_item(query_item(MODE_LOCATE, 48'd1000));
    send_item(query_item(MODE_LOCATE, POS_ALL_ONES));
    send_item(query_item(MODE_NEXT, 48'd0));
    send_item(query_item(MODE_NEXT, 48'd100));
    send_item(query_item(MODE_NEXT, POS_ALL_ONES - 1));
    send_item(query_item(MODE_NEXT, POS_ALL_ONES));
    send_item('{mode: MODE_RESERVED, entry_index: '1, entry_begin: '1,
                entry_length: '1, lookup_pos: '1});

    for (int p = 0; p < RANDOM_PHASES; p++) begin
      write_entries_in_use(phase_limit[p]);
      for (int i = 0; i < ITEMS_PER_PHASE; i++) begin
        send_item(random_item((p == 0) ? 50 : 20));
      end
    end

    start <= 1'b0;
    while (outstanding != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);

    if (fail_count == 0 && outstanding == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule

### interval_table_position_locator.f
rtl/itpl_pkg.sv
rtl/itpl_front.sv
rtl/itpl_back.sv
rtl/interval_table_position_locator.sv
tb/itpl_result_checker.sv
tb/tb_interval_table_position_locator.sv
